### hdl/r2fft_pkg.sv
// Package for the radix-2 DIF FFT: item types, controller commands and twiddle helpers.
`default_nettype none

package r2fft_pkg;

  localparam int FFT_SIZE_DEF = 256;
  localparam int ADDR_W_MAX   = 12;
  localparam int TW_W_MAX     = 11;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint ONE_Q30     = 64'sd1073741824;

  typedef struct packed {
    logic               mode;
    logic signed [15:0] sample_re;
    logic signed [15:0] sample_im;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] bin_re;
    logic signed [23:0] bin_im;
    logic [7:0]         bin_index;
    logic               last;
  } out_item_t;

  typedef enum logic [0:0] {
    MODE_LOAD  = 1'b0,
    MODE_FETCH = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    WSEL_SAMPLE,
    WSEL_SUM,
    WSEL_BFLY
  } wsel_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RA,
    ST_RB,
    ST_ADD,
    ST_MUL,
    ST_WB,
    ST_READY,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic                  we;
    wsel_e                 wsel;
    logic [ADDR_W_MAX-1:0] waddr;
    logic [ADDR_W_MAX-1:0] raddr;
    logic [TW_W_MAX-1:0]   tw_idx;
  } cmd_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] index;
    logic       last;
  } status_t;

  function automatic logic signed [23:0] sat24(input logic signed [41:0] v);
    logic signed [23:0] r;
    if (v > 42'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -42'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  // Signed division truncating towards zero, by shift and subtract, for building the table.
  function automatic longint div_trunc(input longint n, input longint d);
    longint un, ud, q, rem;
    bit     neg;
    neg = (n < 0) != (d < 0);
    un  = (n < 0) ? -n : n;
    ud  = (d < 0) ? -d : d;
    q   = 0;
    rem = 0;
    for (int b = 62; b >= 0; b--) begin
      rem = (rem <<< 1) | ((un >>> b) & 64'sd1);
      q   = q <<< 1;
      if (rem >= ud) begin
        rem = rem - ud;
        q   = q | 64'sd1;
      end
    end
    return neg ? -q : q;
  endfunction

  // Taylor series of sine or cosine for a Q30 angle in 0 to pi/4.
  function automatic longint taylor_q30(input longint a, input bit want_sin);
    longint a2, ts, tc, rs, rc;
    a2 = (a * a) >>> 30;
    ts = a;
    tc = ONE_Q30;
    rs = a;
    rc = ONE_Q30;
    for (int k = 1; k <= 8; k++) begin
      ts = div_trunc((ts * a2) >>> 30, longint'((2 * k) * (2 * k + 1)));
      tc = div_trunc((tc * a2) >>> 30, longint'((2 * k - 1) * (2 * k)));
      if (k[0] == 1'b1) begin
        rs = rs - ts;
        rc = rc - tc;
      end else begin
        rs = rs + ts;
        rc = rc + tc;
      end
    end
    return want_sin ? rs : rc;
  endfunction

  function automatic int q30_to_q15(input longint v);
    longint t;
    t = (v < 0) ? 64'sd0 : v;
    return int'((t + 64'sd16384) >>> 15);
  endfunction

endpackage

`default_nettype wire

### hdl/radix2_dif_fft.sv
// Top level of the radix-2 decimation-in-frequency FFT.
// A frame of FFT_SIZE samples is loaded with one load item per cycle; the final load starts an
// in-place transform that runs N/2*log2(N) butterflies on one shared butterfly unit, each through
// RA, RB, ADD, MUL and WB on the sample store's single read and single write port, while busy is
// high. Fetch items then return one bin each, in natural order, one fetch at a time, with last
// marking the final bin. Results appear on result_o for one cycle with result_valid_o and cannot
// be held off. Loads while a frame waits to be fetched, and fetches with no frame, are ignored.
`default_nettype none

module radix2_dif_fft
  import r2fft_pkg::*;
#(
  parameter int FFT_SIZE = FFT_SIZE_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  input  wire in_item_t item_i,
  output logic          result_valid_o,
  output out_item_t     result_o,
  input  wire logic     cfg_valid_i,
  output logic          cfg_ready_o,
  input  wire logic     cfg_inverse_i
);

  cmd_t               cmd;
  status_t            status;
  logic               inverse_q;
  logic signed [23:0] rd_re, rd_im;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inverse_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      inverse_q <= cfg_inverse_i;
    end
  end

  r2fft_ctrl #(
    .FFT_SIZE(FFT_SIZE)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .mode_i  (item_i.mode),
    .busy_o  (busy),
    .cmd_o   (cmd),
    .status_o(status)
  );

  r2fft_dp #(
    .FFT_SIZE(FFT_SIZE)
  ) u_dp (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .inverse_i  (inverse_q),
    .sample_re_i(item_i.sample_re),
    .sample_im_i(item_i.sample_im),
    .rd_re_o    (rd_re),
    .rd_im_o    (rd_im)
  );

  assign result_valid_o     = status.valid;
  assign result_o.bin_re    = rd_re;
  assign result_o.bin_im    = rd_im;
  assign result_o.bin_index = status.index;
  assign result_o.last      = status.last;

endmodule

`default_nettype wire

### hdl/r2fft_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module r2fft_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

### hdl/r2fft_dp.sv
// Datapath of the FFT: sample store, twiddle table, butterfly adders and multipliers.
`default_nettype none

module r2fft_dp
  import r2fft_pkg::*;
#(
  parameter int FFT_SIZE = FFT_SIZE_DEF
) (
  input  wire logic               clk_i,
  input  wire cmd_t               cmd_i,
  input  wire logic               inverse_i,
  input  wire logic signed [15:0] sample_re_i,
  input  wire logic signed [15:0] sample_im_i,
  output logic signed      [23:0] rd_re_o,
  output logic signed      [23:0] rd_im_o
);

  localparam int LOG2N = $clog2(FFT_SIZE);
  localparam int TW_N  = FFT_SIZE / 2;
  localparam int HW    = (LOG2N > 1) ? LOG2N - 1 : 1;

  logic signed [16:0] tw_cos [TW_N];
  logic signed [16:0] tw_sin [TW_N];

  for (genvar g = 0; g < TW_N; g++) begin : g_tw
    localparam int     Q    = (4 * g) / FFT_SIZE;
    localparam int     R    = 4 * g - Q * FFT_SIZE;
    localparam bit     MIR  = (2 * R > FFT_SIZE);
    localparam longint ANG  = MIR ? (HALF_PI_Q30 * longint'(FFT_SIZE - R)) / FFT_SIZE
                                  : (HALF_PI_Q30 * longint'(R)) / FFT_SIZE;
    localparam int     SA   = q30_to_q15(taylor_q30(ANG, 1'b1));
    localparam int     CA   = q30_to_q15(taylor_q30(ANG, 1'b0));
    localparam int     CPHI = MIR ? SA : CA;
    localparam int     SPHI = MIR ? CA : SA;
    localparam int     CV   = (Q == 0) ? CPHI : (Q == 1) ? -SPHI : (Q == 2) ? -CPHI : SPHI;
    localparam int     SV   = (Q == 0) ? SPHI : (Q == 1) ? CPHI : (Q == 2) ? -SPHI : -CPHI;
    assign tw_cos[g] = 17'(CV);
    assign tw_sin[g] = 17'(SV);
  end

  logic [47:0]        rdata;
  logic [47:0]        wdata;
  logic signed [23:0] b_re, b_im, a_re_q, a_im_q;
  logic signed [23:0] sum_re_q, sum_im_q, d_re_q, d_im_q;
  logic signed [16:0] wc_q, ws_q;
  logic signed [40:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [41:0] t_re, t_im;
  logic signed [23:0] bf_re, bf_im;
  logic [HW-1:0]      tw_idx;

  assign b_re   = rdata[47:24];
  assign b_im   = rdata[23:0];
  assign tw_idx = cmd_i.tw_idx[HW-1:0];

  always_ff @(posedge clk_i) begin
    a_re_q   <= b_re;
    a_im_q   <= b_im;
    sum_re_q <= sat24(42'(a_re_q) + 42'(b_re));
    sum_im_q <= sat24(42'(a_im_q) + 42'(b_im));
    d_re_q   <= sat24(42'(a_re_q) - 42'(b_re));
    d_im_q   <= sat24(42'(a_im_q) - 42'(b_im));
    wc_q     <= tw_cos[tw_idx];
    ws_q     <= inverse_i ? tw_sin[tw_idx] : -tw_sin[tw_idx];
    p_rr_q   <= d_re_q * wc_q;
    p_ii_q   <= d_im_q * ws_q;
    p_ri_q   <= d_re_q * ws_q;
    p_ir_q   <= d_im_q * wc_q;
  end

  assign t_re  = (42'(p_rr_q) - 42'(p_ii_q) + 42'sd16384) >>> 15;
  assign t_im  = (42'(p_ri_q) + 42'(p_ir_q) + 42'sd16384) >>> 15;
  assign bf_re = sat24(t_re);
  assign bf_im = sat24(t_im);

  always_comb begin
    case (cmd_i.wsel)
      WSEL_SAMPLE: wdata = {24'(sample_re_i), 24'(sample_im_i)};
      WSEL_SUM:    wdata = {sum_re_q, sum_im_q};
      WSEL_BFLY:   wdata = {bf_re, bf_im};
      default:     wdata = {bf_re, bf_im};
    endcase
  end

  r2fft_ram #(
    .WIDTH(48),
    .DEPTH(FFT_SIZE)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.we),
    .waddr_i(cmd_i.waddr[LOG2N-1:0]),
    .wdata_i(wdata),
    .raddr_i(cmd_i.raddr[LOG2N-1:0]),
    .rdata_o(rdata)
  );

  assign rd_re_o = b_re;
  assign rd_im_o = b_im;

endmodule

`default_nettype wire

### hdl/r2fft_ctrl.sv
// Controller of the FFT: load, butterfly sequencing over the stages and bin fetch.
`default_nettype none

module r2fft_ctrl
  import r2fft_pkg::*;
#(
  parameter int FFT_SIZE = FFT_SIZE_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire logic mode_i,
  output logic      busy_o,
  output cmd_t      cmd_o,
  output status_t   status_o
);

  localparam int LOG2N   = $clog2(FFT_SIZE);
  localparam int HW      = (LOG2N > 1) ? LOG2N - 1 : 1;
  localparam int SW      = (LOG2N > 1) ? $clog2(LOG2N) : 1;
  localparam int BF_LAST = FFT_SIZE / 2 - 1;

  state_e           state_q, state_d;
  logic [LOG2N-1:0] load_q, load_d, fetch_q, fetch_d, idx_q, idx_d;
  logic [HW-1:0]    bf_q, bf_d;
  logic [SW-1:0]    stage_q, stage_d;
  logic             take, do_load, do_fetch, last_load, last_bf, last_stage;
  logic [LOG2N-1:0] b_ext, mask, addr_i, addr_k, tw_full;

  function automatic logic [LOG2N-1:0] bitrev(input logic [LOG2N-1:0] v);
    logic [LOG2N-1:0] r;
    for (int n = 0; n < LOG2N; n++) begin
      r[n] = v[LOG2N-1-n];
    end
    return r;
  endfunction

  assign take       = start_i && !busy_o;
  assign do_load    = take && (mode_i == MODE_LOAD) && (state_q == ST_IDLE);
  assign do_fetch   = take && (mode_i == MODE_FETCH) && (state_q == ST_READY);
  assign last_load  = (load_q == LOG2N'(FFT_SIZE - 1));
  assign last_bf    = (bf_q == HW'(BF_LAST));
  assign last_stage = (stage_q == SW'(LOG2N - 1));

  assign b_ext   = LOG2N'(bf_q);
  assign mask    = LOG2N'((FFT_SIZE >> (stage_q + 1)) - 1);
  assign addr_i  = ((b_ext & ~mask) << 1) | (b_ext & mask);
  assign addr_k  = addr_i | (mask + LOG2N'(1));
  assign tw_full = (b_ext & mask) << stage_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (do_load && last_load) state_d = ST_RA;
      ST_RA:    state_d = ST_RB;
      ST_RB:    state_d = ST_ADD;
      ST_ADD:   state_d = ST_MUL;
      ST_MUL:   state_d = ST_WB;
      ST_WB:    state_d = (last_bf && last_stage) ? ST_READY : ST_RA;
      ST_READY: if (do_fetch) state_d = ST_OUT;
      ST_OUT:   state_d = (idx_q == LOG2N'(FFT_SIZE - 1)) ? ST_IDLE : ST_READY;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy_o       = !((state_q == ST_IDLE) || (state_q == ST_READY));
    cmd_o.we     = 1'b0;
    cmd_o.wsel   = WSEL_SAMPLE;
    cmd_o.waddr  = ADDR_W_MAX'(load_q);
    cmd_o.raddr  = ADDR_W_MAX'(addr_i);
    cmd_o.tw_idx = TW_W_MAX'(tw_full[HW-1:0]);
    case (state_q)
      ST_IDLE: cmd_o.we = do_load;
      ST_RB:   cmd_o.raddr = ADDR_W_MAX'(addr_k);
      ST_MUL: begin
        cmd_o.we    = 1'b1;
        cmd_o.wsel  = WSEL_SUM;
        cmd_o.waddr = ADDR_W_MAX'(addr_i);
      end
      ST_WB: begin
        cmd_o.we    = 1'b1;
        cmd_o.wsel  = WSEL_BFLY;
        cmd_o.waddr = ADDR_W_MAX'(addr_k);
      end
      ST_READY: cmd_o.raddr = ADDR_W_MAX'(bitrev(fetch_q));
      default: ;
    endcase
    status_o.valid = (state_q == ST_OUT);
    status_o.index = 8'(idx_q);
    status_o.last  = (idx_q == LOG2N'(FFT_SIZE - 1));
  end

  always_comb begin
    load_d  = do_load ? load_q + LOG2N'(1) : load_q;
    fetch_d = do_fetch ? fetch_q + LOG2N'(1) : fetch_q;
    idx_d   = do_fetch ? fetch_q : idx_q;
    bf_d    = bf_q;
    stage_d = stage_q;
    if (do_load && last_load) begin
      bf_d    = '0;
      stage_d = '0;
      fetch_d = '0;
    end else if (state_q == ST_WB) begin
      if (last_bf) begin
        bf_d    = '0;
        stage_d = stage_q + SW'(1);
      end else begin
        bf_d = bf_q + HW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      load_q  <= '0;
      fetch_q <= '0;
      idx_q   <= '0;
      bf_q    <= '0;
      stage_q <= '0;
    end else begin
      state_q <= state_d;
      load_q  <= load_d;
      fetch_q <= fetch_d;
      idx_q   <= idx_d;
      bf_q    <= bf_d;
      stage_q <= stage_d;
    end
  end

  a_fetch_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_fetch |=> status_o.valid)
    else $error("fetch accepted without a result in the next cycle");

  a_last_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status_o.valid && status_o.last) |=> (state_q == ST_IDLE))
    else $error("frame not closed after the last bin");

  a_load_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_load && last_load) |=> busy_o)
    else $error("transform did not start after the final sample");

  a_no_result_in_xform: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.we && (cmd_o.wsel != WSEL_SAMPLE) |-> !status_o.valid)
    else $error("result issued while the transform writes the store");

endmodule

`default_nettype wire
